[src/bcrs_pkg.sv]
// bcrs_pkg: shared types and constants for the blit command register setup unit
// covers register offsets, command words, job record and write-slot sequence
// no dependencies
package bcrs_pkg;

   localparam int unsigned COORD_LIMIT = 8191;
   localparam int unsigned PITCH_LIMIT = 16383;

   localparam int unsigned ADDR_W  = 21;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COORD_W = 13;
   localparam int unsigned PITCH_W = 15;
   localparam int unsigned REQ_TDATA_W = 240;
   localparam int unsigned RSP_TDATA_W = 56;

   localparam logic [ADDR_W-1:0] A_CLIPMIN = 21'h100008;
   localparam logic [ADDR_W-1:0] A_CLIPMAX = 21'h10000c;
   localparam logic [ADDR_W-1:0] A_DBASE   = 21'h100010;
   localparam logic [ADDR_W-1:0] A_DFMT    = 21'h100014;
   localparam logic [ADDR_W-1:0] A_KEYMIN  = 21'h100018;
   localparam logic [ADDR_W-1:0] A_KEYMAX  = 21'h10001c;
   localparam logic [ADDR_W-1:0] A_ROPREG  = 21'h100030;
   localparam logic [ADDR_W-1:0] A_SBASE   = 21'h100034;
   localparam logic [ADDR_W-1:0] A_CMDEXT  = 21'h100038;
   localparam logic [ADDR_W-1:0] A_SFMT    = 21'h100054;
   localparam logic [ADDR_W-1:0] A_SXY     = 21'h10005c;
   localparam logic [ADDR_W-1:0] A_FORE    = 21'h100064;
   localparam logic [ADDR_W-1:0] A_DSIZE   = 21'h100068;
   localparam logic [ADDR_W-1:0] A_DXY     = 21'h10006c;
   localparam logic [ADDR_W-1:0] A_CMD     = 21'h100070;

   localparam logic [DATA_W-1:0] FULL_CLIP  = 32'h1fff1fff;
   localparam logic [DATA_W-1:0] KEYED_ROPS = 32'h00aaaacc;
   localparam logic [DATA_W-1:0] OP_BLT     = 32'h00000001;
   localparam logic [DATA_W-1:0] OP_RECT    = 32'h00000005;
   localparam logic [DATA_W-1:0] BIT_GO     = 32'h00000100;
   localparam logic [DATA_W-1:0] BIT_XDIR   = 32'h00004000;
   localparam logic [DATA_W-1:0] BIT_YDIR   = 32'h00008000;
   localparam logic [DATA_W-1:0] ROP_SRC_SHIFTED = 32'hcc000000;

   localparam logic [2:0] FMT_8BPP  = 3'd1;
   localparam logic [2:0] FMT_16BPP = 3'd3;
   localparam logic [2:0] FMT_32BPP = 3'd5;

   localparam logic REQ_OP_COPY = 1'b0;
   localparam logic REQ_OP_FILL = 1'b1;
   localparam logic STATUS_WRITE  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // one prepared request, everything the write sequence needs
   typedef struct packed {
      logic              reject;
      logic              fill;
      logic              key;
      logic [DATA_W-1:0] dbase;
      logic [DATA_W-1:0] sbase;
      logic [DATA_W-1:0] dfmt;
      logic [DATA_W-1:0] sfmt;
      logic [DATA_W-1:0] color;
      logic [DATA_W-1:0] key_high;
      logic [DATA_W-1:0] sxy;
      logic [DATA_W-1:0] dsize;
      logic [DATA_W-1:0] dxy;
      logic [DATA_W-1:0] cmd;
   } job_type;

   typedef enum logic [3:0] {
      WR_CLIPMIN,
      WR_CLIPMAX,
      WR_DBASE,
      WR_DFMT,
      WR_SBASE,
      WR_SFMT,
      WR_CMDEXT,
      WR_ROP,
      WR_KEYMIN,
      WR_KEYMAX,
      WR_SXY,
      WR_FORE,
      WR_DSIZE,
      WR_DXY,
      WR_CMD,
      WR_REJECT
   } wr_kind_type;

   function automatic wr_kind_type kind_next(wr_kind_type kind, logic fill, logic key);
      wr_kind_type nxt;
      nxt = WR_CMD;
      case (kind)
         WR_CLIPMIN: nxt = WR_CLIPMAX;
         WR_CLIPMAX: nxt = WR_DBASE;
         WR_DBASE:   nxt = WR_DFMT;
         WR_DFMT:    nxt = fill ? WR_CMDEXT : WR_SBASE;
         WR_SBASE:   nxt = WR_SFMT;
         WR_SFMT:    nxt = WR_CMDEXT;
         WR_CMDEXT:  nxt = fill ? WR_FORE : WR_ROP;
         WR_ROP:     nxt = key ? WR_KEYMIN : WR_SXY;
         WR_KEYMIN:  nxt = WR_KEYMAX;
         WR_KEYMAX:  nxt = WR_SXY;
         WR_SXY:     nxt = WR_DSIZE;
         WR_FORE:    nxt = WR_DSIZE;
         WR_DSIZE:   nxt = WR_DXY;
         WR_DXY:     nxt = WR_CMD;
         default:    nxt = WR_CMD;
      endcase
      return nxt;
   endfunction

   function automatic logic [ADDR_W-1:0] kind_addr(wr_kind_type kind);
      logic [ADDR_W-1:0] a;
      a = '0;
      case (kind)
         WR_CLIPMIN: a = A_CLIPMIN;
         WR_CLIPMAX: a = A_CLIPMAX;
         WR_DBASE:   a = A_DBASE;
         WR_DFMT:    a = A_DFMT;
         WR_SBASE:   a = A_SBASE;
         WR_SFMT:    a = A_SFMT;
         WR_CMDEXT:  a = A_CMDEXT;
         WR_ROP:     a = A_ROPREG;
         WR_KEYMIN:  a = A_KEYMIN;
         WR_KEYMAX:  a = A_KEYMAX;
         WR_SXY:     a = A_SXY;
         WR_FORE:    a = A_FORE;
         WR_DSIZE:   a = A_DSIZE;
         WR_DXY:     a = A_DXY;
         WR_CMD:     a = A_CMD;
         default:    a = '0;
      endcase
      return a;
   endfunction

endpackage

[src/blit_command_register_setup_unit.sv]
// blit_command_register_setup_unit: top level of the blit register setup sequencer
// holds the enable register, the issued count and the busy mark, ties builder and sequencer together
// depends on bcrs_pkg, bcrs_build, bcrs_seq
// a request passes the input register, the job register and the output register; first write is CLIPMIN unless rejected
// throughput: one write transaction per cycle from the single output port while rsp_tready does not stall it;
//   a request makes 9 writes (fill), 12 (copy) or 14 (keyed copy), one when rejected
// a new request is taken while the previous one is still writing out
// reset: synchronous, clears handshakes, engine_enabled, issued count and busy mark
module blit_command_register_setup_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_wdata,   // engine_enabled
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bcrs_pkg::REQ_TDATA_W-1:0]  req_tdata,   // dst_offset, dst_pitch, src_offset,
                                                          // src_pitch, pixel_bytes, src_xy,
                                                          // dst_xy, size_wh, color_or_key_low,
                                                          // key_high, key_enable
   input  logic                              req_tuser,   // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcrs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // reg_addr, reg_data, zero pad
   output logic                              rsp_tuser,   // status
   output logic                              rsp_tlast
);
   import bcrs_pkg::*;

   logic        engine_enabled_ff, engine_enabled_in;
   logic [31:0] issued_ops_ff, issued_ops_in;
   logic        engine_busy_ff, engine_busy_in;
   logic        job_valid, job_ready, issue;
   job_type     job;

   bcrs_build u_build (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .engine_enabled (engine_enabled_ff),
      .job_ready      (job_ready),
      .job_valid      (job_valid),
      .job            (job)
   );

   bcrs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a request counts as issued when it enters the sequencer unrejected
   assign issue = job_valid && job_ready && !job.reject;

   always_comb begin
      engine_enabled_in = csr_we ? csr_wdata : engine_enabled_ff;
      issued_ops_in     = issue ? issued_ops_ff + 32'd1 : issued_ops_ff;
      engine_busy_in    = engine_busy_ff || issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engine_enabled_ff <= 1'b0;
         issued_ops_ff     <= '0;
         engine_busy_ff    <= 1'b0;
      end else begin
         engine_enabled_ff <= engine_enabled_in;
         issued_ops_ff     <= issued_ops_in;
         engine_busy_ff    <= engine_busy_in;
      end
   end

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !engine_busy_ff |-> (issued_ops_ff == '0))
      else $error("issued count moved without busy mark");

endmodule

[src/bcrs_build.sv]
// bcrs_build: input register and request check / word builder
// registers one request transaction, then builds the prepared job record combinationally
// depends on bcrs_pkg
module bcrs_build (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bcrs_pkg::REQ_TDATA_W-1:0]  req_tdata,  // dst_offset, dst_pitch, src_offset,
                                                         // src_pitch, pixel_bytes, src_xy,
                                                         // dst_xy, size_wh, color_or_key_low,
                                                         // key_high, key_enable
   input  logic                              req_tuser,  // op
   input  logic                              engine_enabled,
   input  logic                              job_ready,
   output logic                              job_valid,
   output bcrs_pkg::job_type                 job
);
   import bcrs_pkg::*;

   logic                             in_valid_ff, in_valid_in;
   logic [REQ_TDATA_W-1:0]           in_data_ff;
   logic                             in_op_ff;

   logic [31:0]        dst_offset, src_offset, color, key_high;
   logic [PITCH_W-1:0] dst_pitch, src_pitch;
   logic [2:0]         pixel_bytes;
   logic [25:0]        src_xy, dst_xy, size_wh;
   logic               key_enable;

   logic [COORD_W-1:0] sx0, sy, dx0, dy, w, h, h_m1, w_m1;
   logic [3:0]         dskip, sskip;
   logic [13:0]        sx, dx, sx_adj, dx_adj, sy_adj, dy_adj;
   logic [14:0]        sx_end, dx_end, sy_end, dy_end;
   logic               bpp_ok, dpitch_ok, spitch_ok, size_ok, range_ok, same_surf;
   logic               ydir, xdir, is_fill;
   logic [2:0]         fmt_code;
   logic [31:0]        dbase, sbase;

   assign req_tready  = !in_valid_ff || job_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_op_ff   <= req_tuser;
      end
   end

   assign dst_offset  = in_data_ff[31:0];
   assign dst_pitch   = in_data_ff[46:32];
   assign src_offset  = in_data_ff[78:47];
   assign src_pitch   = in_data_ff[93:79];
   assign pixel_bytes = in_data_ff[96:94];
   assign src_xy      = in_data_ff[122:97];
   assign dst_xy      = in_data_ff[148:123];
   assign size_wh     = in_data_ff[174:149];
   assign color       = in_data_ff[206:175];
   assign key_high    = in_data_ff[238:207];
   assign key_enable  = in_data_ff[239];

   always_comb begin
      is_fill = (in_op_ff == REQ_OP_FILL);
      sx0 = src_xy[12:0];
      sy  = src_xy[25:13];
      dx0 = dst_xy[12:0];
      dy  = dst_xy[25:13];
      w   = size_wh[12:0];
      h   = size_wh[25:13];
      w_m1 = w - 13'd1;
      h_m1 = h - 13'd1;

      bpp_ok = pixel_bytes inside {3'd1, 3'd2, 3'd4};
      case (pixel_bytes)
         3'd1: begin
            fmt_code = FMT_8BPP;
            dskip    = dst_offset[3:0];
            sskip    = src_offset[3:0];
         end
         3'd2: begin
            fmt_code = FMT_16BPP;
            dskip    = {1'b0, dst_offset[3:1]};
            sskip    = {1'b0, src_offset[3:1]};
         end
         default: begin
            fmt_code = FMT_32BPP;
            dskip    = {2'b0, dst_offset[3:2]};
            sskip    = {2'b0, src_offset[3:2]};
         end
      endcase

      dbase = {dst_offset[31:4], 4'b0};
      sbase = {src_offset[31:4], 4'b0};
      dx = {1'b0, dx0} + {10'b0, dskip};
      sx = {1'b0, sx0} + {10'b0, sskip};

      dpitch_ok = (dst_pitch != '0) && (dst_pitch <= PITCH_W'(PITCH_LIMIT));
      spitch_ok = (src_pitch != '0) && (src_pitch <= PITCH_W'(PITCH_LIMIT));
      size_ok = (w != '0) && (h != '0) && (w <= COORD_W'(COORD_LIMIT))
                && (h <= COORD_W'(COORD_LIMIT));

      dx_end = {1'b0, dx} + {2'b0, w};
      sx_end = {1'b0, sx} + {2'b0, w};
      dy_end = {2'b0, dy} + {2'b0, h};
      sy_end = {2'b0, sy} + {2'b0, h};
      range_ok = (dx_end <= 15'(COORD_LIMIT)) && (dy_end <= 15'(COORD_LIMIT));
      if (!is_fill) begin
         range_ok = range_ok && (sx_end <= 15'(COORD_LIMIT))
                    && (sy_end <= 15'(COORD_LIMIT));
      end

      // overlap within one surface: walk backwards in y, or in x on the same row
      same_surf = !is_fill && (dbase == sbase) && (dst_pitch == src_pitch);
      ydir = same_surf && (sy < dy);
      xdir = same_surf && (sy == dy) && (sx < dx);
      sy_adj = {1'b0, sy} + (ydir ? {1'b0, h_m1} : 14'd0);
      dy_adj = {1'b0, dy} + (ydir ? {1'b0, h_m1} : 14'd0);
      sx_adj = sx + (xdir ? {1'b0, w_m1} : 14'd0);
      dx_adj = dx + (xdir ? {1'b0, w_m1} : 14'd0);

      job.reject   = !engine_enabled || !size_ok || !dpitch_ok || !bpp_ok
                     || (!is_fill && !spitch_ok) || !range_ok;
      job.fill     = is_fill;
      job.key      = key_enable && !is_fill;
      job.dbase    = dbase;
      job.sbase    = sbase;
      job.dfmt     = {13'b0, fmt_code, 1'b0, dst_pitch};
      job.sfmt     = {13'b0, fmt_code, 1'b0, src_pitch};
      job.color    = color;
      job.key_high = key_high;
      job.sxy      = {2'b0, sy_adj, 3'b0, sx_adj[12:0]};
      job.dsize    = {3'b0, h, 3'b0, w};
      job.dxy      = {2'b0, dy_adj, 3'b0, dx_adj[12:0]};
      if (is_fill) begin
         job.cmd = OP_RECT | BIT_GO | ROP_SRC_SHIFTED;
      end else begin
         job.cmd = OP_BLT | BIT_GO | ROP_SRC_SHIFTED
                   | (xdir ? BIT_XDIR : '0) | (ydir ? BIT_YDIR : '0);
      end
   end

   assign job_valid = in_valid_ff;

endmodule

[src/bcrs_seq.sv]
// bcrs_seq: job register and register-write sequencer with output register
// steps through the write slots of one job, one write transaction per cycle while rsp_tready does not stall it
// depends on bcrs_pkg
module bcrs_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_ready,
   input  bcrs_pkg::job_type                 job,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcrs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // reg_addr, reg_data, zero pad
   output logic                              rsp_tuser,  // status
   output logic                              rsp_tlast
);
   import bcrs_pkg::*;

   logic                job_valid_ff, job_valid_in;
   job_type             job_ff;
   wr_kind_type         kind_ff, kind_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                status_ff, last_ff;
   logic                out_free, emit, kind_last, load;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = job_valid_ff && out_free;
   assign kind_last = (kind_ff == WR_CMD) || (kind_ff == WR_REJECT);
   assign job_ready = !job_valid_ff || (emit && kind_last);
   assign load      = job_ready && job_valid;

   always_comb begin
      job_valid_in = job_valid_ff;
      kind_in      = kind_ff;
      if (load) begin
         job_valid_in = 1'b1;
         kind_in      = job.reject ? WR_REJECT : WR_CLIPMIN;
      end else if (emit && kind_last) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         kind_in = kind_next(kind_ff, job_ff.fill, job_ff.key);
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      case (kind_ff)
         WR_CLIPMIN: data_in = '0;
         WR_CLIPMAX: data_in = FULL_CLIP;
         WR_DBASE:   data_in = job_ff.dbase;
         WR_DFMT:    data_in = job_ff.dfmt;
         WR_SBASE:   data_in = job_ff.sbase;
         WR_SFMT:    data_in = job_ff.sfmt;
         WR_CMDEXT:  data_in = {31'b0, job_ff.key};
         WR_ROP:     data_in = KEYED_ROPS;
         WR_KEYMIN:  data_in = job_ff.color;
         WR_KEYMAX:  data_in = job_ff.key_high;
         WR_SXY:     data_in = job_ff.sxy;
         WR_FORE:    data_in = job_ff.color;
         WR_DSIZE:   data_in = job_ff.dsize;
         WR_DXY:     data_in = job_ff.dxy;
         WR_CMD:     data_in = job_ff.cmd;
         default:    data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         kind_ff      <= WR_CLIPMIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
      if (emit) begin
         addr_ff   <= kind_addr(kind_ff);
         data_ff   <= data_in;
         status_ff <= (kind_ff == WR_REJECT) ? STATUS_REJECT : STATUS_WRITE;
         last_ff   <= kind_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, data_ff, addr_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_REJECT) |-> last_ff && (addr_ff == '0))
      else $error("rejection transaction without last or with an address");

   a_job_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> job_valid_ff && ((kind_ff == WR_CLIPMIN) || (kind_ff == WR_REJECT)))
      else $error("job did not start at the first write slot");

   a_key_only_keyed_copy: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && ((kind_ff == WR_KEYMIN) || (kind_ff == WR_KEYMAX))
      |-> job_ff.key && !job_ff.fill && !job_ff.reject)
      else $error("key write on a request without keying");

   a_cmd_closes: assert property (@(posedge clock) disable iff (reset)
      emit && (kind_ff == WR_CMD) |=> rsp_valid_ff && last_ff && (addr_ff == A_CMD))
      else $error("command write not marked last");

endmodule
